[hdl/zupt_trapezoid_inertial_integrator_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the ZUPT inertial integrator
// Concurrent checks clocked on clk and held off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ZUPT_TRAPEZOID_INERTIAL_INTEGRATOR_ASSERT_SVH
`define ZUPT_TRAPEZOID_INERTIAL_INTEGRATOR_ASSERT_SVH

// Same-cycle implication.
`define ZTI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ZTI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/zti_pkg.sv]
// ---------------------------------------------------------------------------
// zti_pkg
// Types and constants shared by the ZUPT inertial integrator modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package zti_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int VEL_W      = 32;
  localparam int POS_W      = 48;
  localparam int SQ_W       = 48;
  localparam int NORM_W     = 25;
  localparam int RUN_W      = 16;
  localparam int TIME_W     = 48;
  localparam int ROOT_STEPS = 24;

  localparam logic [2:0] CFG_MODE        = 3'd0;
  localparam logic [2:0] CFG_BIAS_X      = 3'd1;
  localparam logic [2:0] CFG_BIAS_Y      = 3'd2;
  localparam logic [2:0] CFG_BIAS_Z      = 3'd3;
  localparam logic [2:0] CFG_ACCEL_LIMIT = 3'd4;
  localparam logic [2:0] CFG_GYRO_LIMIT  = 3'd5;
  localparam logic [2:0] CFG_CONFIRM     = 3'd6;

  localparam int MODE_BIAS = 0;
  localparam int MODE_DET  = 1;
  localparam int MODE_ZUPT = 2;

  localparam logic [2:0]          MODE_RST    = 3'd6;
  localparam logic [SAMPLE_W-1:0] ALIMIT_RST  = 24'd13107;
  localparam logic [SAMPLE_W-1:0] GLIMIT_RST  = 24'd9830;
  localparam logic [RUN_W-1:0]    CONFIRM_RST = 16'd5;
  localparam logic [RUN_W-1:0]    RUN_MAX     = 16'hFFFF;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_ZERO_DT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_VUPD,
    ST_ROOT,
    ST_PMUL,
    ST_PUPD,
    ST_DONE
  } zti_state_t;

  typedef struct packed {
    logic load;
    logic square;
    logic vmul;
    logic vupd;
    logic pmul;
    logic commit;
    logic zupt;
    logic have_prev;
    logic bias_en;
  } lane_ctl_t;

endpackage

`default_nettype wire

[hdl/zti_isqrt.sv]
// ---------------------------------------------------------------------------
// zti_isqrt
// Restoring integer square root, one result bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zti_isqrt (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [zti_pkg::SQ_W-1:0]    radicand,
  output logic                             busy,
  output logic [zti_pkg::NORM_W-1:0]       root
);
  import zti_pkg::*;

  logic [SQ_W-1:0]         n_r;
  logic [ROOT_STEPS+1:0]   rem_r;
  logic [ROOT_STEPS-1:0]   root_r;
  logic [4:0]              cnt_r;
  logic                    busy_r;

  logic [ROOT_STEPS+3:0]   rem_sh;
  logic [ROOT_STEPS+3:0]   trial;
  logic                    fits;

  assign rem_sh = {rem_r, n_r[SQ_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'(ROOT_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Pull two radicand bits per step, keep the partial remainder.
  always_ff @(posedge clk) begin
    if (start) begin
      n_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      n_r <= {n_r[SQ_W-3:0], 2'b00};
      if (fits) begin
        rem_r  <= (ROOT_STEPS + 2)'(rem_sh - trial);
        root_r <= {root_r[ROOT_STEPS-2:0], 1'b1};
      end else begin
        rem_r  <= (ROOT_STEPS + 2)'(rem_sh);
        root_r <= {root_r[ROOT_STEPS-2:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign root = NORM_W'(root_r);

endmodule

`default_nettype wire

[hdl/zti_lane.sv]
// ---------------------------------------------------------------------------
// zti_lane
// One axis: bias removal, squares for the norms, trapezoid velocity and
// position integration.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zti_lane (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire zti_pkg::lane_ctl_t                ctl,
  input  wire logic signed [zti_pkg::SAMPLE_W-1:0] accel,
  input  wire logic signed [zti_pkg::SAMPLE_W-1:0] gyro,
  input  wire logic signed [zti_pkg::SAMPLE_W-1:0] bias,
  input  wire logic [zti_pkg::SAMPLE_W-1:0]      step_time,
  output logic [zti_pkg::SQ_W-1:0]               accel_sq,
  output logic [zti_pkg::SQ_W-1:0]               gyro_sq,
  output logic signed [zti_pkg::VEL_W-1:0]       vel,
  output logic signed [zti_pkg::POS_W-1:0]       pos
);
  import zti_pkg::*;

  localparam int PROD_W = 58;
  localparam int INC_W  = PROD_W - 25;

  localparam logic signed [INC_W:0] VSUM_HI = {{(INC_W + 2 - VEL_W){1'b0}}, {(VEL_W-1){1'b1}}};
  localparam logic signed [INC_W:0] VSUM_LO = {{(INC_W + 2 - VEL_W){1'b1}}, {(VEL_W-1){1'b0}}};

  logic signed [SAMPLE_W-1:0] acc_r, gyr_r, prev_r;
  logic [SQ_W-1:0]            asq_r, gsq_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [VEL_W-1:0]    vnew_r, vel_r;
  logic signed [POS_W-1:0]    pos_r;

  logic signed [SAMPLE_W:0]   diff;
  logic signed [SAMPLE_W-1:0] acc_nxt;
  logic signed [SAMPLE_W+1:0] asum;
  logic signed [SAMPLE_W:0]   dt_s;
  logic signed [PROD_W-1:0]   rnd;
  logic signed [INC_W-1:0]    inc;
  logic signed [INC_W:0]      vsum;
  logic signed [VEL_W-1:0]    vp, vc;
  logic signed [VEL_W:0]      vpair;
  logic signed [POS_W:0]      psum;

  assign diff = SAMPLE_W'(0) + ((SAMPLE_W + 1)'(accel) - (SAMPLE_W + 1)'(bias));
  always_comb begin
    if (!ctl.bias_en) begin
      acc_nxt = accel;
    end else if (diff[SAMPLE_W] != diff[SAMPLE_W-1]) begin
      acc_nxt = diff[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      acc_nxt = diff[SAMPLE_W-1:0];
    end
  end

  assign asum = ctl.have_prev ? (SAMPLE_W + 2)'(prev_r) + (SAMPLE_W + 2)'(acc_r)
                              : (SAMPLE_W + 2)'(acc_r) <<< 1;
  assign dt_s = $signed({1'b0, step_time});

  // Round to nearest, ties up: add half, then floor-shift.
  assign rnd  = (prod_r + PROD_W'(24'sd0 + (1 <<< 24))) >>> 25;
  assign inc  = rnd[INC_W-1:0];
  assign vsum = (INC_W + 1)'(vel_r) + (INC_W + 1)'(inc);
  assign vp    = ctl.zupt ? '0 : vel_r;
  assign vc    = ctl.zupt ? '0 : vnew_r;
  assign vpair = (VEL_W + 1)'(vp) + (VEL_W + 1)'(vc);
  assign psum  = (POS_W + 1)'(pos_r) + (POS_W + 1)'(inc);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc_r <= acc_nxt;
      gyr_r <= gyro;
    end
    if (ctl.square) begin
      asq_r <= SQ_W'(acc_r * acc_r);
      gsq_r <= SQ_W'(gyr_r * gyr_r);
    end
    if (ctl.vmul) begin
      prod_r <= PROD_W'(asum * dt_s);
    end else if (ctl.pmul) begin
      prod_r <= PROD_W'(vpair * dt_s);
    end
    if (ctl.vupd) begin
      if (vsum > VSUM_HI) begin
        vnew_r <= {1'b0, {(VEL_W-1){1'b1}}};
      end else if (vsum < VSUM_LO) begin
        vnew_r <= {1'b1, {(VEL_W-1){1'b0}}};
      end else begin
        vnew_r <= vsum[VEL_W-1:0];
      end
    end
  end

  // Integrator state: commit at the end of a sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_r  <= '0;
      pos_r  <= '0;
      prev_r <= '0;
    end else if (ctl.commit) begin
      vel_r  <= vc;
      prev_r <= acc_r;
      if (psum[POS_W] != psum[POS_W-1]) begin
        pos_r <= psum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end else begin
        pos_r <= psum[POS_W-1:0];
      end
    end
  end

  assign accel_sq = asq_r;
  assign gyro_sq  = gsq_r;
  assign vel      = vel_r;
  assign pos      = pos_r;

endmodule

`default_nettype wire

[hdl/zupt_trapezoid_inertial_integrator.sv]
// ---------------------------------------------------------------------------
// zupt_trapezoid_inertial_integrator
// Dead-reckoning integrator with stillness detection and zero-velocity update.
// ---------------------------------------------------------------------------
// Usage:
//   in_*   : one IMU sample per beat (accel, gyro, step_time, stationary flag).
//   out_*  : one result per sample: position, velocity, detector flags,
//            norms, elapsed time and status.
//   cfg_*  : register writes (index 0..6), always ready; write only while
//            the block is idle.
// Path: for a nonzero step time a sample runs squaring, the velocity update,
//   the two 24-step square root units (which set most of the wait), the
//   position update and commit before out_valid rises; a zero step time
//   skips integration and returns the stored state with status 1.
// Flow: one sample is taken at a time; in_ready is high only in idle.
// Three axis lanes square, integrate velocity and position side by side;
// the merge stage sums squares, runs two root units and decides stillness.
// Reset: position, velocity, previous accel, run count, elapsed time and
//   reported flags clear; registers return to their defaults.
// Stall: a finished result sits in the output register; the block holds
//   the next sample's result until the receiver takes the waiting beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zupt_trapezoid_inertial_integrator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [23:0] in_accel_x,
  input  wire logic [23:0] in_accel_y,
  input  wire logic [23:0] in_accel_z,
  input  wire logic [23:0] in_gyro_x,
  input  wire logic [23:0] in_gyro_y,
  input  wire logic [23:0] in_gyro_z,
  input  wire logic [23:0] in_step_time,
  input  wire logic        in_external_stationary,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [47:0]      out_pos_x,
  output logic [47:0]      out_pos_y,
  output logic [47:0]      out_pos_z,
  output logic [31:0]      out_vel_x,
  output logic [31:0]      out_vel_y,
  output logic [31:0]      out_vel_z,
  output logic             out_still_detected,
  output logic             out_zupt_done,
  output logic [24:0]      out_accel_norm,
  output logic [24:0]      out_gyro_norm,
  output logic [47:0]      out_elapsed,
  output logic             out_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  import zti_pkg::*;

  // Configuration registers.
  logic [2:0]          mode_r;
  logic [SAMPLE_W-1:0] bias_r [3];
  logic [SAMPLE_W-1:0] alimit_r, glimit_r;
  logic [RUN_W-1:0]    confirm_r;

  // Control and merge state.
  zti_state_t          state_r, state_nxt;
  logic [SAMPLE_W-1:0] dt_r;
  logic                ext_r, err_r, have_prev_r;
  logic [RUN_W-1:0]    run_r;
  logic [TIME_W-1:0]   time_r;
  logic                last_still_r, last_zupt_r;
  logic [NORM_W-1:0]   last_anorm_r, last_gnorm_r;

  // Output register.
  logic                out_valid_r;

  lane_ctl_t           ctl;
  logic                sq_start, out_load, det_step, in_acc;
  logic [SAMPLE_W-1:0] accel_in [3];
  logic [SAMPLE_W-1:0] gyro_in [3];
  logic [SQ_W-1:0]     asq [3];
  logic [SQ_W-1:0]     gsq [3];
  logic signed [VEL_W-1:0] vel [3];
  logic signed [POS_W-1:0] pos [3];
  logic [SQ_W-1:0]     asum, gsum;
  logic                abusy, gbusy;
  logic [NORM_W-1:0]   aroot, groot;
  logic [NORM_W-1:0]   anorm, gnorm;
  logic                both_still, still, zupt;
  logic [RUN_W-1:0]    run_nxt, need;

  assign accel_in = '{in_accel_x, in_accel_y, in_accel_z};
  assign gyro_in  = '{in_gyro_x, in_gyro_y, in_gyro_z};
  assign in_acc   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_RST;
      bias_r    <= '{'0, '0, '0};
      alimit_r  <= ALIMIT_RST;
      glimit_r  <= GLIMIT_RST;
      confirm_r <= CONFIRM_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE:        mode_r    <= cfg_data[2:0];
        CFG_BIAS_X:      bias_r[0] <= cfg_data;
        CFG_BIAS_Y:      bias_r[1] <= cfg_data;
        CFG_BIAS_Z:      bias_r[2] <= cfg_data;
        CFG_ACCEL_LIMIT: alimit_r  <= cfg_data;
        CFG_GYRO_LIMIT:  glimit_r  <= cfg_data;
        CFG_CONFIRM:     confirm_r <= cfg_data[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // Three axis lanes.
  for (genvar i = 0; i < 3; i++) begin : g_lane
    zti_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .accel     ($signed(accel_in[i])),
      .gyro      ($signed(gyro_in[i])),
      .bias      ($signed(bias_r[i])),
      .step_time (dt_r),
      .accel_sq  (asq[i]),
      .gyro_sq   (gsq[i]),
      .vel       (vel[i]),
      .pos       (pos[i])
    );
  end

  // Merge: sum of squares feeds the two root units.
  assign asum = asq[0] + asq[1] + asq[2];
  assign gsum = gsq[0] + gsq[1] + gsq[2];

  zti_isqrt u_aroot (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(asum),
    .busy(abusy), .root(aroot)
  );
  zti_isqrt u_groot (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(gsum),
    .busy(gbusy), .root(groot)
  );

  // Stillness detector and zero-velocity decision.
  always_comb begin
    anorm      = mode_r[MODE_DET] ? aroot : '0;
    gnorm      = mode_r[MODE_DET] ? groot : '0;
    both_still = (anorm <= NORM_W'(alimit_r)) && (gnorm <= NORM_W'(glimit_r));
    need       = (confirm_r == '0) ? RUN_W'(1) : confirm_r;
    if (!mode_r[MODE_DET]) begin
      run_nxt = run_r;
    end else if (!both_still) begin
      run_nxt = '0;
    end else if (run_r == RUN_MAX) begin
      run_nxt = run_r;
    end else begin
      run_nxt = run_r + RUN_W'(1);
    end
    still = mode_r[MODE_DET] && (run_nxt >= need);
    zupt  = ext_r || (mode_r[MODE_ZUPT] && still);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ctl           = '0;
    ctl.zupt      = last_zupt_r;
    ctl.have_prev = have_prev_r;
    ctl.bias_en   = mode_r[MODE_BIAS];
    sq_start      = 1'b0;
    det_step      = 1'b0;
    out_load      = 1'b0;
    in_ready      = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = (in_step_time == '0) ? ST_DONE : ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        ctl.square = 1'b1;
        state_nxt  = ST_SUM;
      end
      ST_SUM: begin
        sq_start  = 1'b1;
        ctl.vmul  = 1'b1;
        state_nxt = ST_VUPD;
      end
      ST_VUPD: begin
        ctl.vupd  = 1'b1;
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        if (!abusy && !gbusy) begin
          det_step  = 1'b1;
          state_nxt = ST_PMUL;
        end
      end
      ST_PMUL: begin
        ctl.pmul  = 1'b1;
        state_nxt = ST_PUPD;
      end
      ST_PUPD: begin
        ctl.commit = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sample latch.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dt_r  <= in_step_time;
      ext_r <= in_external_stationary;
      err_r <= (in_step_time == '0) ? STATUS_ZERO_DT : STATUS_OK;
    end
  end

  // Detector and time state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r        <= '0;
      time_r       <= '0;
      have_prev_r  <= 1'b0;
      last_still_r <= 1'b0;
      last_zupt_r  <= 1'b0;
      last_anorm_r <= '0;
      last_gnorm_r <= '0;
    end else begin
      if (det_step) begin
        run_r        <= run_nxt;
        last_still_r <= still;
        last_zupt_r  <= zupt;
        last_anorm_r <= anorm;
        last_gnorm_r <= gnorm;
      end
      if (ctl.commit) begin
        time_r      <= time_r + TIME_W'(dt_r);
        have_prev_r <= 1'b1;
      end
    end
  end

  // Output register: hold the beat until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pos_x          <= pos[0];
      out_pos_y          <= pos[1];
      out_pos_z          <= pos[2];
      out_vel_x          <= vel[0];
      out_vel_y          <= vel[1];
      out_vel_z          <= vel[2];
      out_still_detected <= last_still_r;
      out_zupt_done      <= last_zupt_r;
      out_accel_norm     <= last_anorm_r;
      out_gyro_norm      <= last_gnorm_r;
      out_elapsed        <= time_r;
      out_status         <= err_r;
    end
  end

  assign out_valid = out_valid_r;

`include "zupt_trapezoid_inertial_integrator_assert.svh"

  `ZTI_ASSERT_NEXT(a_zero_dt_skip, in_acc && (in_step_time == '0), state_r == ST_DONE, "zero step time must skip integration")
  `ZTI_ASSERT_NOW(a_zupt_zero_vel, out_valid && out_zupt_done, (out_vel_x == '0) && (out_vel_y == '0) && (out_vel_z == '0), "zero-velocity update left nonzero velocity")
  `ZTI_ASSERT_NOW(a_root_window, abusy || gbusy, (state_r == ST_VUPD) || (state_r == ST_ROOT), "root unit busy outside its window")

endmodule

`default_nettype wire
